/* hw/rtl/sieb_pkg.sv */
`timescale 1ns / 1ps

package sieb_pkg;

  localparam int VAL_W = 31;
  localparam int CFG_W = 5;
  localparam int POS_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_UPD  = 2'd1;
  localparam cell_op_t OP_ROT  = 2'd2;

  typedef struct packed {
    cell_op_t op;
    logic     in_use;
    logic     is_last;
    logic     use_down;
    logic     up_shift;
    logic     dn_shift;
    logic     dn_here;
  } cell_ctrl_t;

endpackage

/* hw/rtl/sorted_insert_evict_min_buffer_unit.sv */
`timescale 1ns / 1ps
// channel | direction | ports                                     | handshake
// in      | input     | in_value                                  | in_valid / in_ready
// out     | output    | out_position out_content out_is_full out_last | out_valid / out_ready
// cfg     | input     | cfg_wr_data (cells in use)                | cfg_wr_en, no wait
//
// an item is taken in the idle state, then one update step (skipped for a zero value)
// covers the whole row of cells, then the ring rotates, one beat per cell in use,
// through cell 0, which drives the result port.
// reset (synchronous, rst_n low) empties every cell and clears full mode.
// a stalled out_ready freezes the rotation; no new item is taken until the dump ends.

module sorted_insert_evict_min_buffer_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sieb_pkg::VAL_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sieb_pkg::POS_W-1:0]   out_position,
  output logic [sieb_pkg::VAL_W-1:0]   out_content,
  output logic                         out_is_full,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [sieb_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] ONES = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [sieb_pkg::CFG_W-1:0]  cfg_r;
  logic [LW-1:0]               len_r, len_nxt;
  logic [LW-1:0]               cnt_r, cnt_nxt;
  logic [sieb_pkg::VAL_W-1:0]  v_r, v_nxt;
  logic                        full_r, full_nxt;

  sieb_pkg::cell_op_t          op;
  sieb_pkg::cell_ctrl_t        ctrl [CAPACITY];
  logic [sieb_pkg::VAL_W-1:0]  vals [CAPACITY];

  logic [CAPACITY-1:0] m_vec, g_vec, nz_vec, use_vec, last_vec;
  logic [CAPACITY-1:0] bef_vec, a_vec, here_vec, fs_vec;
  logic                up_found, use_down, last_beat;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = (state_r == ST_DUMP);
  assign out_content  = vals[0];
  assign out_position = sieb_pkg::POS_W'(cnt_r);
  assign out_is_full  = full_r;
  assign last_beat    = (cnt_r == (len_r - LW'(1)));
  assign out_last     = last_beat;

  assign up_found = |(m_vec & use_vec);
  assign use_down = full_r || !up_found;

  // cells in use, clamped to 1..CAPACITY
  always_comb begin
    if (cfg_r == '0) begin
      len_nxt = LW'(1);
    end else if (32'(cfg_r) > CAPACITY) begin
      len_nxt = LW'(CAPACITY);
    end else begin
      len_nxt = LW'(cfg_r);
    end
  end

  genvar t;
  generate
    for (t = 0; t < CAPACITY; t++) begin : g_row
      localparam logic [CAPACITY-1:0] LOW_T = ONES >> (CAPACITY - t);

      assign use_vec[t]  = (len_r > LW'(t));
      assign last_vec[t] = (len_r == LW'(t + 1));
      // some earlier cell already takes the new value: shift up from below
      assign bef_vec[t]  = |(m_vec & use_vec & LOW_T);

      if (t < CAPACITY - 1) begin : g_a
        localparam logic [CAPACITY-1:0] LOW_T2 = ONES >> (CAPACITY - t - 2);
        // cell sits below the eviction insert point: shift down from above
        assign a_vec[t] = !(|(g_vec & use_vec & LOW_T2)) && use_vec[t + 1];
      end else begin : g_a_end
        assign a_vec[t] = 1'b0;
      end

      if (t == 0) begin : g_h0
        assign here_vec[t] = !a_vec[t];
        assign fs_vec[t]   = last_vec[t] && (m_vec[t] || nz_vec[t]);
      end else begin : g_hn
        assign here_vec[t] = !a_vec[t] && a_vec[t - 1];
        assign fs_vec[t]   = last_vec[t] &&
                             (bef_vec[t] ? nz_vec[t - 1] : (m_vec[t] || nz_vec[t]));
      end

      assign ctrl[t].op       = op;
      assign ctrl[t].in_use   = use_vec[t];
      assign ctrl[t].is_last  = last_vec[t];
      assign ctrl[t].use_down = use_down;
      assign ctrl[t].up_shift = bef_vec[t];
      assign ctrl[t].dn_shift = a_vec[t];
      assign ctrl[t].dn_here  = here_vec[t];

      sieb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl[t]),
        .ins_val  (v_r),
        .prev_val ((t == 0) ? '0 : vals[(t == 0) ? 0 : t - 1]),
        .next_val ((t == CAPACITY - 1) ? '0 : vals[(t == CAPACITY - 1) ? t : t + 1]),
        .head_val (vals[0]),
        .val      (vals[t]),
        .up_match (m_vec[t]),
        .dn_match (g_vec[t]),
        .nz       (nz_vec[t])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    full_nxt  = full_r;
    op        = sieb_pkg::OP_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt     = in_value;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (v_r != '0) begin
          op       = sieb_pkg::OP_UPD;
          full_nxt = full_r || use_down || (|fs_vec);
        end
        cnt_nxt   = '0;
        state_nxt = ST_DUMP;
      end
      ST_DUMP: begin
        if (out_ready) begin
          op      = sieb_pkg::OP_ROT;
          cnt_nxt = cnt_r + LW'(1);
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_r   <= sieb_pkg::CFG_RESET;
      full_r  <= 1'b0;
      cnt_r   <= '0;
      len_r   <= LW'(1);
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

/* hw/rtl/sieb_cell.sv */
`timescale 1ns / 1ps

module sieb_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sieb_pkg::cell_ctrl_t     ctrl,
  input  logic [sieb_pkg::VAL_W-1:0] ins_val,
  input  logic [sieb_pkg::VAL_W-1:0] prev_val,
  input  logic [sieb_pkg::VAL_W-1:0] next_val,
  input  logic [sieb_pkg::VAL_W-1:0] head_val,
  output logic [sieb_pkg::VAL_W-1:0] val,
  output logic                     up_match,
  output logic                     dn_match,
  output logic                     nz
);

  logic [sieb_pkg::VAL_W-1:0] val_r;
  logic [sieb_pkg::VAL_W-1:0] val_nxt;

  assign val      = val_r;
  assign nz       = (val_r != '0);
  // empty cells count as larger while filling, never while evicting
  assign up_match = (ins_val < val_r) || !nz;
  assign dn_match = nz && (val_r >= ins_val);

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      sieb_pkg::OP_UPD: begin
        if (ctrl.in_use) begin
          if (ctrl.use_down) begin
            if (ctrl.dn_shift) begin
              val_nxt = next_val;
            end else if (ctrl.dn_here) begin
              val_nxt = ins_val;
            end
          end else begin
            if (ctrl.up_shift) begin
              val_nxt = prev_val;
            end else if (up_match) begin
              val_nxt = ins_val;
            end
          end
        end
      end
      sieb_pkg::OP_ROT: begin
        if (ctrl.in_use) begin
          val_nxt = ctrl.is_last ? head_val : next_val;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule
